[sv/iss_pkg.sv]
// Package for the indexed sequence store: widths, operation and status codes,
// the controller state type and the result record. No dependencies.
`default_nettype none

package iss_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = ADDR_W + 1;
  localparam int DATA_W = 32;

  // Stream widths: in_tdata = {value, position}, out_tdata padded to whole bytes.
  localparam int IN_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + DATA_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]         element_count;
    logic signed [DATA_W-1:0] read_value;
    stat_t                    status;
  } res_t;

endpackage

`default_nettype wire

[sv/iss_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; used by the indexed sequence store for its element memory.
`default_nettype none

module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/indexed_sequence_store.sv]
// Top level of the indexed sequence store: controller, count register and output stage.
// Depends on iss_pkg and iss_ram.
`default_nettype none

// Ordered store of up to 256 signed 32-bit elements with an element count.
// Input transactions carry the operation on in_tuser (write at position,
// append, delete at position, read) and position and value on in_tdata.
// Every input transaction yields exactly one output transaction carrying a
// status, the value read (zero unless a successful read) and the count after
// the operation.
// The elements live in one simple dual-port RAM with registered read data.
// Write, append and rejected operations pass from the accepting edge through
// S_DONE to the output register; a read passes through S_READ and S_DONE. A
// delete moves every later element down by one position, one element per
// cycle through the RAM read and write ports, in S_SHIFT, then goes to S_DONE.
// One item is worked on at a time; in_tready is high whenever the controller
// is idle, which it becomes when the result is loaded into the output
// register, so no transaction is accepted while one is still in progress.
// A finished result sits in the output register until the receiver takes it;
// the next input transaction is accepted meanwhile, and its result waits in a
// holding register if the output register is still occupied.
// Reset clears the count, the controller and the output valid flag. The RAM
// is not cleared: only positions below the count are ever read, and those
// have always been written.
module indexed_sequence_store (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [iss_pkg::IN_TDATA_W-1:0]    in_tdata,  // position[7:0], value[39:8]
  input  wire logic [1:0]                        in_tuser,  // func[1:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [iss_pkg::OUT_TDATA_W-1:0]   out_tdata  // status[1:0], read_value[33:2],
                                                            // element_count[42:34], zeros above
);

  localparam int AW = iss_pkg::ADDR_W;
  localparam int CW = iss_pkg::CNT_W;

  iss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  iss_pkg::res_t   res_r, res_nxt;
  iss_pkg::res_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [iss_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [iss_pkg::DATA_W-1:0] ram_rdata;

  iss_pkg::op_t              in_op;
  logic [AW-1:0]             in_pos;
  logic [iss_pkg::DATA_W-1:0] in_val;
  logic [CW-1:0]             target;
  logic                      out_free;

  assign in_op  = iss_pkg::op_t'(in_tuser);
  assign in_pos = in_tdata[AW-1:0];
  assign in_val = in_tdata[AW +: iss_pkg::DATA_W];

  iss_ram #(
    .WIDTH(iss_pkg::DATA_W),
    .DEPTH(iss_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iss_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == iss_pkg::S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r;
    target        = {1'b0, in_pos};

    unique case (state_r)
      iss_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_nxt.status     = iss_pkg::STAT_OK;
          res_nxt.read_value = '0;
          state_nxt          = iss_pkg::S_DONE;
          unique case (in_op) inside
            iss_pkg::OP_WRITE, iss_pkg::OP_APPEND: begin
              // Append is a write at the current count.
              if (in_op == iss_pkg::OP_APPEND) begin
                target = cnt_r;
              end
              ram_wdata = in_val;
              ram_waddr = target[AW-1:0];
              if (target < cnt_r) begin
                ram_we = 1'b1;
              end else if (target == cnt_r) begin
                if (cnt_r == CW'(iss_pkg::CAPACITY)) begin
                  res_nxt.status = iss_pkg::STAT_FULL;
                end else begin
                  ram_we  = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
              end else begin
                res_nxt.status = iss_pkg::STAT_BAD_POS;
              end
            end
            iss_pkg::OP_DELETE: begin
              if (target >= cnt_r) begin
                res_nxt.status = iss_pkg::STAT_BAD_POS;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
                // Later elements exist: start the shift by fetching position + 1.
                if (target < cnt_nxt) begin
                  ram_raddr = in_pos + 1'b1;
                  idx_nxt   = in_pos;
                  state_nxt = iss_pkg::S_SHIFT;
                end
              end
            end
            iss_pkg::OP_READ: begin
              if (target >= cnt_r) begin
                res_nxt.status = iss_pkg::STAT_BAD_POS;
              end else begin
                ram_raddr = in_pos;
                state_nxt = iss_pkg::S_READ;
              end
            end
            default: begin
              res_nxt.status = iss_pkg::STAT_BAD_POS;
            end
          endcase
          res_nxt.element_count = cnt_nxt;
        end
      end
      iss_pkg::S_READ: begin
        res_nxt.read_value = ram_rdata;
        state_nxt          = iss_pkg::S_DONE;
      end
      iss_pkg::S_SHIFT: begin
        // The element fetched last cycle moves down into idx_r; the next one
        // is fetched while the count (already decremented) is not reached.
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (({1'b0, idx_r} + 1'b1) < cnt_r) begin
          ram_raddr = idx_r + 2'd2;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          state_nxt = iss_pkg::S_DONE;
        end
      end
      iss_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = iss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = iss_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(iss_pkg::OUT_TDATA_W - iss_pkg::OUT_BITS){1'b0}}, out_r};

endmodule

`default_nettype wire
